>>> rtl/byscl_pkg.sv
// byscl_pkg: shared types and constants of the bilinear YUV scaler.
// Holds the sequencer state type, size ceilings, operation, register and plane codes.
// No dependencies.
`default_nettype none

package byscl_pkg;

  // Source store dimensions; source sizes saturate here.
  localparam int MAX_SRC_WIDTH  = 128;
  localparam int MAX_SRC_HEIGHT = 128;

  // Destination size ceiling; target sizes saturate here.
  localparam int MAX_DST_SIZE = 1024;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

  // Operation codes of an input transfer.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // Plane codes, processed in this order.
  localparam logic [1:0] PLANE_Y = 2'd0;
  localparam logic [1:0] PLANE_U = 2'd1;
  localparam logic [1:0] PLANE_V = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRD_Y,   // source row numerator
    ST_DIV_Y,   // row quotient and remainder
    ST_CRD_X,   // source column numerator
    ST_DIV_X,   // column quotient and remainder
    ST_READ,    // issue four store reads
    ST_RDEND,   // capture last read
    ST_MUL_A,   // top-left weight product
    ST_MUL_B,   // plus bottom-left
    ST_DIV_L,   // left column blend
    ST_MUL_C,   // top-right weight product
    ST_MUL_D,   // plus bottom-right
    ST_DIV_R,   // right column blend
    ST_MUL_E,   // left weight product
    ST_MUL_F,   // plus right
    ST_DIV_O    // final horizontal blend
  } state_t;

endpackage

`default_nettype wire

>>> rtl/bilinear_yuv_scaler_unit.sv
// bilinear_yuv_scaler_unit: planar YUV bilinear resizer with a source frame store.
// Uses byscl_pkg for the sequencer state type, size ceilings and code constants.
// Single module: store, shared multiplier, shared radix-4 divider, sequencer.
//
//  channel   handshake          payload
//  --------  -----------------  ---------------------------------------------------
//  input     start / busy       in_operation, in_load_col, in_load_row, in_luma_in,
//                               in_cb_in, in_cr_in, in_out_col, in_out_row
//  result    out_valid strobe   out_luma_out, out_cb_out, out_cr_out
//  config    cfg_we             cfg_index, cfg_wdata
//
// A transfer on the input channel happens at a clock edge with start high and busy low.
// A load transfer writes the store at that edge, never raises busy; one per idle cycle.
// A compute transfer keeps busy high until all three planes are done; the result strobe comes in the
// first cycle with busy low again, and a new transfer may be taken in that same cycle.
// Busy time is set by one shared 8x11 multiplier and one divider retiring two
// quotient bits per cycle: 11 divisions, 20 products and the store reads.
// Reset is synchronous, active low; it clears the sequencer and sets every size
// register to 128. The store has no reset. Results cannot be held off by the receiver.
`default_nettype none

module bilinear_yuv_scaler_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [byscl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [10:0]                   cfg_wdata,
  // input channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_operation,
  input  wire logic [6:0]                    in_load_col,
  input  wire logic [6:0]                    in_load_row,
  input  wire logic [7:0]                    in_luma_in,
  input  wire logic [7:0]                    in_cb_in,
  input  wire logic [7:0]                    in_cr_in,
  input  wire logic [9:0]                    in_out_col,
  input  wire logic [9:0]                    in_out_row,
  // result channel
  output logic                               out_valid,
  output logic [7:0]                         out_luma_out,
  output logic [7:0]                         out_cb_out,
  output logic [7:0]                         out_cr_out
);

  import byscl_pkg::*;

  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // ---------------------------------------------------------------------------
  // Configuration registers and their saturated views
  // ---------------------------------------------------------------------------
  logic [7:0]  src_w_r, src_h_r;
  logic [10:0] dst_w_r, dst_h_r;
  logic [7:0]  sw_c, sh_c;
  logic [10:0] tw_c, th_c;

  // Treat a zero size as one and clip oversized values to the supported maximum.
  always_comb begin
    if (src_w_r == 8'd0) begin
      sw_c = 8'd1;
    end else if (32'(src_w_r) > 32'(MAX_SRC_WIDTH)) begin
      sw_c = 8'(MAX_SRC_WIDTH);
    end else begin
      sw_c = src_w_r;
    end
    if (src_h_r == 8'd0) begin
      sh_c = 8'd1;
    end else if (32'(src_h_r) > 32'(MAX_SRC_HEIGHT)) begin
      sh_c = 8'(MAX_SRC_HEIGHT);
    end else begin
      sh_c = src_h_r;
    end
    if (dst_w_r == 11'd0) begin
      tw_c = 11'd1;
    end else if (32'(dst_w_r) > 32'(MAX_DST_SIZE)) begin
      tw_c = 11'(MAX_DST_SIZE);
    end else begin
      tw_c = dst_w_r;
    end
    if (dst_h_r == 11'd0) begin
      th_c = 11'd1;
    end else if (32'(dst_h_r) > 32'(MAX_DST_SIZE)) begin
      th_c = 11'(MAX_DST_SIZE);
    end else begin
      th_c = dst_h_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_t      state_r, state_nxt;
  logic [1:0]  step_r, step_nxt;     // divider step or read slot
  logic [1:0]  plane_r, plane_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic        take;                 // input transfer this edge
  logic        take_load, take_comp;

  assign busy      = (state_r != ST_IDLE);
  assign take      = start && !busy;
  assign take_load = take && (in_operation == OP_LOAD);
  assign take_comp = take && (in_operation == OP_COMPUTE);

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  logic [9:0]  ocol_r, orow_r;
  logic [18:0] acc_r;
  logic [10:0] div_rem_r;
  logic [7:0]  div_dvd_r;            // dividend bits in, quotient bits out
  logic [7:0]  y0_r, x0_r;
  logic [10:0] yr_r, xr_r;
  logic [23:0] pix_r [4];            // (y0,x0) (y1,x0) (y0,x1) (y1,x1)
  logic [23:0] rd_data_r;
  logic [7:0]  left_r, right_r;
  logic [7:0]  luma_r, cb_r, cr_r;

  logic [23:0] mem [DEPTH];

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  logic div_run, div_last;

  assign div_run  = state_r inside {ST_DIV_Y, ST_DIV_X, ST_DIV_L, ST_DIV_R, ST_DIV_O};
  assign div_last = div_run && (step_r == 2'd3);

  always_comb begin
    state_nxt = state_r;
    plane_nxt = plane_r;
    step_nxt  = (div_run || state_r == ST_READ) ? step_r + 2'd1 : 2'd0;
    case (state_r)
      ST_IDLE: begin
        plane_nxt = PLANE_Y;
        if (take_comp) state_nxt = ST_CRD_Y;
      end
      ST_CRD_Y: state_nxt = ST_DIV_Y;
      ST_DIV_Y: if (div_last) state_nxt = ST_CRD_X;
      ST_CRD_X: state_nxt = ST_DIV_X;
      ST_DIV_X: if (div_last) state_nxt = ST_READ;
      ST_READ:  if (step_r == 2'd3) state_nxt = ST_RDEND;
      ST_RDEND: state_nxt = ST_MUL_A;
      ST_MUL_A: state_nxt = ST_MUL_B;
      ST_MUL_B: state_nxt = ST_DIV_L;
      ST_DIV_L: if (div_last) state_nxt = ST_MUL_C;
      ST_MUL_C: state_nxt = ST_MUL_D;
      ST_MUL_D: state_nxt = ST_DIV_R;
      ST_DIV_R: if (div_last) state_nxt = ST_MUL_E;
      ST_MUL_E: state_nxt = ST_MUL_F;
      ST_MUL_F: state_nxt = ST_DIV_O;
      ST_DIV_O: begin
        if (div_last) begin
          plane_nxt = plane_r + 2'd1;
          state_nxt = (plane_r == PLANE_V) ? ST_IDLE : ST_MUL_A;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs of the sequencer: operand steering for the shared units
  // ---------------------------------------------------------------------------
  logic [7:0]  mul_a;
  logic [10:0] mul_b;
  logic        acc_add;              // add the held partial product
  logic        acc_cap;              // hold the first product of a pair
  logic        div_load;             // seed the divider with the sum
  logic [10:0] divisor;
  logic [7:0]  pix_byte [4];

  // Pick the current plane out of each neighbor pixel.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pix_byte[k] = pix_r[k][{plane_r, 3'b000} +: 8];
    end
  end

  always_comb begin
    mul_a    = 8'd0;
    mul_b    = 11'd0;
    acc_add  = 1'b0;
    acc_cap  = 1'b0;
    div_load = 1'b0;
    divisor  = (state_r inside {ST_DIV_X, ST_DIV_O}) ? tw_c : th_c;
    out_valid_nxt = div_last && (state_r == ST_DIV_O) && (plane_r == PLANE_V);
    case (state_r)
      ST_CRD_Y: begin
        mul_a = sh_c;  mul_b = {1'b0, orow_r};  div_load = 1'b1;
      end
      ST_CRD_X: begin
        mul_a = sw_c;  mul_b = {1'b0, ocol_r};  div_load = 1'b1;
      end
      ST_MUL_A: begin
        mul_a = pix_byte[0];  mul_b = th_c - yr_r;  acc_cap = 1'b1;
      end
      ST_MUL_B: begin
        mul_a = pix_byte[1];  mul_b = yr_r;  acc_add = 1'b1;  div_load = 1'b1;
      end
      ST_MUL_C: begin
        mul_a = pix_byte[2];  mul_b = th_c - yr_r;  acc_cap = 1'b1;
      end
      ST_MUL_D: begin
        mul_a = pix_byte[3];  mul_b = yr_r;  acc_add = 1'b1;  div_load = 1'b1;
      end
      ST_MUL_E: begin
        mul_a = left_r;  mul_b = tw_c - xr_r;  acc_cap = 1'b1;
      end
      ST_MUL_F: begin
        mul_a = right_r;  mul_b = xr_r;  acc_add = 1'b1;  div_load = 1'b1;
      end
      default: begin
        mul_a = 8'd0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shared multiply-add. Every sum stays below 256 times its divisor, so it fits
  // in 19 bits and its quotient in 8 bits.
  // ---------------------------------------------------------------------------
  logic [18:0] prod, sum;

  assign prod = 19'(mul_a) * 19'(mul_b);
  assign sum  = prod + (acc_add ? acc_r : 19'd0);

  // ---------------------------------------------------------------------------
  // Shared divider: restoring, two quotient bits per cycle.
  // The top 11 dividend bits start below the divisor since the quotient is < 256.
  // ---------------------------------------------------------------------------
  logic [11:0] t1, t2;
  logic        ge1, ge2;
  logic [10:0] r1, rem_step;
  logic [7:0]  dvd_step;

  always_comb begin
    t1       = {div_rem_r, div_dvd_r[7]};
    ge1      = (t1 >= {1'b0, divisor});
    r1       = ge1 ? 11'(t1 - {1'b0, divisor}) : t1[10:0];
    t2       = {r1, div_dvd_r[6]};
    ge2      = (t2 >= {1'b0, divisor});
    rem_step = ge2 ? 11'(t2 - {1'b0, divisor}) : t2[10:0];
    dvd_step = {div_dvd_r[5:0], ge1, ge2};
  end

  // ---------------------------------------------------------------------------
  // Neighbor coordinates and store addresses
  // ---------------------------------------------------------------------------
  logic [8:0]    y0_inc, x0_inc;
  logic [7:0]    y1, x1;
  logic [7:0]    rd_row, rd_col;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_ok;

  // Clamp the second neighbor to the last row or column.
  assign y0_inc = {1'b0, y0_r} + 9'd1;
  assign x0_inc = {1'b0, x0_r} + 9'd1;
  assign y1     = (y0_inc < {1'b0, sh_c}) ? y0_inc[7:0] : sh_c - 8'd1;
  assign x1     = (x0_inc < {1'b0, sw_c}) ? x0_inc[7:0] : sw_c - 8'd1;

  // Read slot bit 0 picks the lower row, bit 1 the right column.
  assign rd_row  = step_r[0] ? y1 : y0_r;
  assign rd_col  = step_r[1] ? x1 : x0_r;
  assign rd_addr = AW'(rd_row) * AW'(MAX_SRC_WIDTH) + AW'(rd_col);

  // Drop loads that fall outside the store.
  assign wr_ok   = (32'(in_load_col) < 32'(MAX_SRC_WIDTH)) &&
                   (32'(in_load_row) < 32'(MAX_SRC_HEIGHT));
  assign wr_addr = AW'(in_load_row) * AW'(MAX_SRC_WIDTH) + AW'(in_load_col);

  // ---------------------------------------------------------------------------
  // Frame store: one write port for loads, one registered read port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (take_load && wr_ok) begin
      mem[wr_addr] <= {in_cr_in, in_cb_in, in_luma_in};
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 2'd0;
      plane_r     <= PLANE_Y;
      out_valid_r <= 1'b0;
      src_w_r     <= 8'd128;
      src_h_r     <= 8'd128;
      dst_w_r     <= 11'd128;
      dst_h_r     <= 11'd128;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      plane_r     <= plane_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_WIDTH:  src_w_r <= cfg_wdata[7:0];
          REG_SRC_HEIGHT: src_h_r <= cfg_wdata[7:0];
          REG_DST_WIDTH:  dst_w_r <= cfg_wdata;
          REG_DST_HEIGHT: dst_h_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    // Saturate the destination position at the last column and row.
    if (take_comp) begin
      ocol_r <= ({1'b0, in_out_col} > tw_c - 11'd1) ? 10'(tw_c - 11'd1) : in_out_col;
      orow_r <= ({1'b0, in_out_row} > th_c - 11'd1) ? 10'(th_c - 11'd1) : in_out_row;
    end

    if (acc_cap) acc_r <= sum;

    if (div_load) begin
      div_rem_r <= sum[18:8];
      div_dvd_r <= sum[7:0];
    end else if (div_run) begin
      div_rem_r <= rem_step;
      div_dvd_r <= dvd_step;
    end

    // Capture the quotient, and for the coordinate divisions the remainder, on the last divider step.
    if (div_last) begin
      case (state_r)
        ST_DIV_Y: begin
          y0_r <= dvd_step;
          yr_r <= rem_step;
        end
        ST_DIV_X: begin
          x0_r <= dvd_step;
          xr_r <= rem_step;
        end
        ST_DIV_L: left_r  <= dvd_step;
        ST_DIV_R: right_r <= dvd_step;
        ST_DIV_O: begin
          case (plane_r)
            PLANE_Y: luma_r <= dvd_step;
            PLANE_U: cb_r   <= dvd_step;
            default: cr_r   <= dvd_step;
          endcase
        end
        default: ;
      endcase
    end

    // Read data arrives the cycle after its address; at ST_RDEND the slot index wraps to the last one.
    if ((state_r == ST_READ && step_r != 2'd0) || state_r == ST_RDEND) begin
      pix_r[step_r - 2'd1] <= rd_data_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_luma_out = luma_r;
  assign out_cb_out   = cb_r;
  assign out_cr_out   = cr_r;

endmodule

`default_nettype wire
